[hw/rtl/pwc_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pwc_pkg: shared types and constants for the pulse width capture block
// Request and result layouts, phase and error codes.
// ---------------------------------------------------------------------------
package pwc_pkg;

	localparam int PIN_W    = 5;
	localparam int SAMPLE_W = 16;
	localparam int COUNT_W  = 32;
	localparam int ERR_W    = 2;

	// Request kinds
	localparam logic REQ_START = 1'b0;
	localparam logic REQ_TICK  = 1'b1;

	typedef enum logic [1:0] {
		PH_IDLE       = 2'd0,
		PH_WAIT_END   = 2'd1,
		PH_WAIT_START = 2'd2,
		PH_MEASURE    = 2'd3
	} phase_t;

	typedef enum logic [ERR_W-1:0] {
		ERR_OK      = 2'd0,
		ERR_PIN     = 2'd1,
		ERR_TIMEOUT = 2'd2
	} err_t;

	// One input request
	typedef struct packed {
		logic                req_type;
		logic [PIN_W-1:0]    pin_number;
		logic                pulse_level;
		logic [COUNT_W-1:0]  timeout_ticks;
		logic [SAMPLE_W-1:0] pin_levels;
	} req_t;

	// One result, with its valid flag
	typedef struct packed {
		logic               valid;
		logic [COUNT_W-1:0] width;
		err_t               err;
	} res_t;

endpackage

[hw/rtl/pwc_in_reg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pwc_in_reg: input request register
// Captures one request per cycle; holds it while the result side is blocked.
// ---------------------------------------------------------------------------
module pwc_in_reg
	import pwc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  req_t req_in,
	input  logic advance,
	output logic valid_s1,
	output req_t req_s1
);

	logic accept;

	// stall only when a held request cannot move on
	assign in_stall = valid_s1 & ~advance;
	assign accept   = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req_in;
		end
	end

endmodule

[hw/rtl/pwc_engine.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pwc_engine: measurement state and per-request update
// Phase sequencing, saturating tick counters and timeout check.
// ---------------------------------------------------------------------------
module pwc_engine
	import pwc_pkg::*;
#(
	parameter int NUM_PINS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic fire,
	input  req_t req,
	output res_t res
);

	localparam logic [PIN_W:0] MAX_PIN = (PIN_W+1)'(NUM_PINS);

	phase_t             phase_q, phase_d;
	logic [PIN_W-1:0]   pin_q, pin_d;
	logic               level_q, level_d;
	logic [COUNT_W-1:0] limit_q, limit_d;
	logic [COUNT_W-1:0] elapsed_q, elapsed_d;
	logic [COUNT_W-1:0] width_q, width_d;
	logic               sample;
	logic               pin_ok;
	logic               finished;

	assign pin_ok = (req.pin_number != '0) && ({1'b0, req.pin_number} <= MAX_PIN);

	// pins past the sample word read as low
	assign sample = pin_q[PIN_W-1] ? 1'b0 : req.pin_levels[pin_q[PIN_W-2:0]];

	// next state and result
	always_comb begin
		phase_d   = phase_q;
		pin_d     = pin_q;
		level_d   = level_q;
		limit_d   = limit_q;
		elapsed_d = elapsed_q;
		width_d   = width_q;
		finished  = 1'b0;
		res.valid = 1'b0;
		res.width = '0;
		res.err   = ERR_OK;
		if (req.req_type == REQ_START) begin
			if (!pin_ok) begin
				phase_d   = PH_IDLE;
				res.valid = 1'b1;
				res.err   = ERR_PIN;
			end else begin
				pin_d     = req.pin_number - PIN_W'(1);
				level_d   = req.pulse_level;
				limit_d   = req.timeout_ticks;
				elapsed_d = '0;
				width_d   = '0;
				phase_d   = PH_WAIT_END;
			end
		end else if (phase_q != PH_IDLE) begin
			unique case (phase_q)
				PH_WAIT_END: begin
					if (sample != level_q) phase_d = PH_WAIT_START;
				end
				PH_WAIT_START: begin
					if (sample == level_q) begin
						phase_d = PH_MEASURE;
						width_d = COUNT_W'(1);
					end
				end
				PH_MEASURE: begin
					if (sample == level_q) begin
						if (width_q != '1) width_d = width_q + COUNT_W'(1);
					end else begin
						finished  = 1'b1;
						phase_d   = PH_IDLE;
						res.valid = 1'b1;
						res.width = width_q;
						res.err   = ERR_OK;
					end
				end
				default: ;
			endcase
			// timeout runs over all phases; completion wins
			if (!finished) begin
				if (elapsed_q != '1) elapsed_d = elapsed_q + COUNT_W'(1);
				if (elapsed_d >= limit_q) begin
					phase_d   = PH_IDLE;
					res.valid = 1'b1;
					res.width = '0;
					res.err   = ERR_TIMEOUT;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			pin_q     <= '0;
			level_q   <= 1'b0;
			limit_q   <= '0;
			elapsed_q <= '0;
			width_q   <= '0;
		end else if (fire) begin
			phase_q   <= phase_d;
			pin_q     <= pin_d;
			level_q   <= level_d;
			limit_q   <= limit_d;
			elapsed_q <= elapsed_d;
			width_q   <= width_d;
		end
	end

endmodule

[hw/rtl/pwc_out_reg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pwc_out_reg: result register
// Holds one result until the downstream side takes it.
// ---------------------------------------------------------------------------
module pwc_out_reg
	import pwc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fire,
	input  res_t               res,
	output logic               advance,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [COUNT_W-1:0] pulse_width,
	output logic [ERR_W-1:0]   error_code
);

	logic               valid_q;
	logic [COUNT_W-1:0] width_q;
	err_t               err_q;
	logic               load;

	// room when empty or being drained this cycle
	assign advance = ~valid_q | ~out_stall;
	assign load    = fire & res.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			width_q <= res.width;
			err_q   <= res.err;
		end
	end

	assign out_valid   = valid_q;
	assign pulse_width = width_q;
	assign error_code  = err_q;

endmodule

[hw/rtl/pulse_width_capture_top.sv]
`timescale 1ns / 1ps
// A request waits in the input register until the result register has room.
// Throughput: one request per cycle while in_stall is low; the phase and counter update is one pass.
// A held result blocks new requests only while out_stall is high.
// Reset (arst_n low, asynchronous): phase idle, counters and pin cleared,
// no request or result held.
// ---------------------------------------------------------------------------
// pulse_width_capture_top: pulse width measurement with timeout
// Input register, measurement engine and result register.
// ---------------------------------------------------------------------------
module pulse_width_capture_top
	import pwc_pkg::*;
#(
	parameter int NUM_PINS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                req_type,
	input  logic [PIN_W-1:0]    pin_number,
	input  logic                pulse_level,
	input  logic [COUNT_W-1:0]  timeout_ticks,
	input  logic [SAMPLE_W-1:0] pin_levels,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [COUNT_W-1:0]  pulse_width,
	output logic [ERR_W-1:0]    error_code
);

	req_t req_in, req_s1;
	res_t res;
	logic valid_s1;
	logic advance;
	logic fire;

	assign req_in = '{req_type:      req_type,
	                  pin_number:    pin_number,
	                  pulse_level:   pulse_level,
	                  timeout_ticks: timeout_ticks,
	                  pin_levels:    pin_levels};

	// a held request is processed when the result register has room
	assign fire = valid_s1 & advance;

	pwc_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.req_in   (req_in),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.req_s1   (req_s1)
	);

	pwc_engine #(
		.NUM_PINS (NUM_PINS)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.req    (req_s1),
		.res    (res)
	);

	pwc_out_reg u_out_reg (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.res         (res),
		.advance     (advance),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.pulse_width (pulse_width),
		.error_code  (error_code)
	);

endmodule

[tb/pulse_width_capture_top_test.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pulse_width_capture_top_test: self-checking bench for pulse width capture
// A queue-fed driver sends start and tick requests. Each accepted request
// runs through a local model of the capture engine. A monitor compares each
// result with the oldest one due. Sender and receiver idle at random across
// several phases, with one long receiver hold-off.
// ---------------------------------------------------------------------------
module pulse_width_capture_top_test;
	import pwc_pkg::*;

	localparam int CAPTURE_PINS = 16;
	localparam int PHASE_ITEMS  = 380;
	localparam int HOLD_CYCLES  = 300;
	localparam int QUIET_LIMIT  = 2000;

	// Expected result of one measurement
	typedef struct {
		logic [COUNT_W-1:0] width;
		err_t               err;
	} capture_t;

	logic                clk;
	logic                arst_n        = 1'b0;
	logic                in_valid      = 1'b0;
	logic                in_stall;
	logic                req_type      = REQ_START;
	logic [PIN_W-1:0]    pin_number    = '0;
	logic                pulse_level   = 1'b0;
	logic [COUNT_W-1:0]  timeout_ticks = '0;
	logic [SAMPLE_W-1:0] pin_levels    = '0;
	logic                out_valid;
	logic                out_stall     = 1'b0;
	logic [COUNT_W-1:0]  pulse_width;
	logic [ERR_W-1:0]    error_code;

	req_t     pending[$];
	capture_t captures_due[$];
	req_t     cur_req;
	capture_t due;
	int       mismatches     = 0;
	int       send_idle_pct  = 0;
	int       recv_stall_pct = 0;
	int       hold_asks      = 0;
	int       hold_seen      = 0;
	int       hold_left      = 0;
	int       quiet_cycles   = 0;

	// Local copy of the capture engine state
	phase_t             m_phase   = PH_IDLE;
	logic [3:0]         m_pin     = '0;
	logic               m_level   = 1'b0;
	logic [COUNT_W-1:0] m_limit   = '0;
	logic [COUNT_W-1:0] m_elapsed = '0;
	logic [COUNT_W-1:0] m_width   = '0;

	pulse_width_capture_top #(
		.NUM_PINS(CAPTURE_PINS)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.req_type     (req_type),
		.pin_number   (pin_number),
		.pulse_level  (pulse_level),
		.timeout_ticks(timeout_ticks),
		.pin_levels   (pin_levels),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.pulse_width  (pulse_width),
		.error_code   (error_code)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Advance the capture engine by one accepted request
	task automatic track_capture(input req_t r);
		capture_t res;
		logic     lvl;
		logic     done;
		done = 1'b0;
		if (r.req_type == REQ_START) begin
			if (r.pin_number == 0 || r.pin_number > CAPTURE_PINS) begin
				m_phase   = PH_IDLE;
				res.width = '0;
				res.err   = ERR_PIN;
				captures_due.push_back(res);
			end else begin
				m_pin     = 4'(r.pin_number - 5'd1);
				m_level   = r.pulse_level;
				m_limit   = r.timeout_ticks;
				m_elapsed = '0;
				m_width   = '0;
				m_phase   = PH_WAIT_END;
			end
		end else if (m_phase != PH_IDLE) begin
			lvl = r.pin_levels[m_pin];
			case (m_phase)
				PH_WAIT_END: begin
					if (lvl != m_level)
						m_phase = PH_WAIT_START;
				end
				PH_WAIT_START: begin
					if (lvl == m_level) begin
						m_phase = PH_MEASURE;
						m_width = COUNT_W'(1);
					end
				end
				default: begin
					if (lvl == m_level) begin
						if (m_width != '1)
							m_width = m_width + 1;
					end else begin
						m_phase   = PH_IDLE;
						res.width = m_width;
						res.err   = ERR_OK;
						captures_due.push_back(res);
						done      = 1'b1;
					end
				end
			endcase
			// timeout runs over all phases; a finished pulse wins
			if (!done) begin
				if (m_elapsed != '1)
					m_elapsed = m_elapsed + 1;
				if (m_elapsed >= m_limit) begin
					m_phase   = PH_IDLE;
					res.width = '0;
					res.err   = ERR_TIMEOUT;
					captures_due.push_back(res);
				end
			end
		end
	endtask

	task automatic push_start(input int pin, input logic lvl, input logic [COUNT_W-1:0] tmo);
		req_t r;
		r.req_type      = REQ_START;
		r.pin_number    = PIN_W'(pin);
		r.pulse_level   = lvl;
		r.timeout_ticks = tmo;
		r.pin_levels    = SAMPLE_W'($urandom);
		pending.push_back(r);
	endtask

	task automatic push_tick(input logic [SAMPLE_W-1:0] levels);
		req_t r;
		r.req_type      = REQ_TICK;
		r.pin_number    = PIN_W'($urandom);
		r.pulse_level   = 1'($urandom);
		r.timeout_ticks = $urandom;
		r.pin_levels    = levels;
		pending.push_back(r);
	endtask

	// Random sample word with the watched pin forced to a level
	function automatic logic [SAMPLE_W-1:0] levels_with(input int pin, input logic lvl);
		logic [SAMPLE_W-1:0] v;
		v          = SAMPLE_W'($urandom);
		v[pin - 1] = lvl;
		return v;
	endfunction

	// One measurement: mostly well formed, some cut short, some noise
	task automatic add_pulse_run();
		int                 kind;
		int                 pin;
		int                 pick;
		int                 n;
		logic               lvl;
		logic [COUNT_W-1:0] tmo;
		kind = $urandom_range(99);
		pin  = $urandom_range(CAPTURE_PINS, 1);
		lvl  = 1'($urandom);
		pick = $urandom_range(99);
		if (pick < 60)
			tmo = $urandom_range(30, 0);
		else if (pick < 90)
			tmo = $urandom;
		else
			tmo = '1;
		if (kind < 8) begin
			push_start($urandom_range(1) ? 0 : $urandom_range(31, CAPTURE_PINS + 1), lvl, tmo);
			repeat ($urandom_range(3)) push_tick(SAMPLE_W'($urandom));
		end else begin
			push_start(pin, lvl, tmo);
			repeat ($urandom_range(3)) push_tick(levels_with(pin, lvl));
			repeat ($urandom_range(4, 1)) push_tick(levels_with(pin, !lvl));
			n = ($urandom_range(19) == 0) ? $urandom_range(60, 13) : $urandom_range(12, 1);
			if (kind < 18)
				n = $urandom_range(n);
			repeat (n) push_tick(levels_with(pin, lvl));
			// cut-short runs leave the next start to restart the block
			if (kind >= 18)
				push_tick(levels_with(pin, !lvl));
		end
	endtask

	// Request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				track_capture(cur_req);
			if (!in_valid || !in_stall) begin
				if (pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					cur_req        = pending.pop_front();
					req_type      <= cur_req.req_type;
					pin_number    <= cur_req.pin_number;
					pulse_level   <= cur_req.pulse_level;
					timeout_ticks <= cur_req.timeout_ticks;
					pin_levels    <= cur_req.pin_levels;
					in_valid      <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor and receiver stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (captures_due.size() == 0) begin
					$display("%0t: unexpected result, expected none, got width %0d error %0d",
						$time, pulse_width, error_code);
					mismatches++;
				end else begin
					due = captures_due.pop_front();
					if (pulse_width !== due.width) begin
						$display("%0t: pulse_width expected %0d, got %0d",
							$time, due.width, pulse_width);
						mismatches++;
					end
					if (error_code !== due.err) begin
						$display("%0t: error_code expected %0d, got %0d",
							$time, due.err, error_code);
						mismatches++;
					end
				end
			end
			// long hold-off lets the block fill and stall its input
			if (hold_asks != hold_seen) begin
				hold_seen <= hold_asks;
				hold_left <= HOLD_CYCLES;
				out_stall <= 1'b1;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	// Watchdog on cycles with no handshake on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles == QUIET_LIMIT) begin
				$display("pulse_width_capture_top_test: errors");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// Stimulus and run control
	initial begin
		int send_pcts[4];
		int recv_pcts[4];
		send_pcts = '{0, 55, 0, 27};
		recv_pcts = '{0, 0, 55, 27};

		// directed: tick while idle, bad pins
		push_tick(SAMPLE_W'($urandom));
		push_start(0, 1'b1, 5);
		push_start(CAPTURE_PINS + 1, 1'b0, 5);
		push_start(31, 1'b1, '1);
		// high pulse on pin 1 that is already high at start
		push_start(1, 1'b1, 100);
		push_tick(levels_with(1, 1'b1));
		push_tick(levels_with(1, 1'b0));
		push_tick(levels_with(1, 1'b1));
		push_tick(levels_with(1, 1'b1));
		push_tick(levels_with(1, 1'b0));
		// low pulse on the top pin, longest timeout
		push_start(CAPTURE_PINS, 1'b0, '1);
		push_tick(levels_with(CAPTURE_PINS, 1'b1));
		push_tick(levels_with(CAPTURE_PINS, 1'b0));
		push_tick(levels_with(CAPTURE_PINS, 1'b1));
		// zero timeout
		push_start(5, 1'b1, 0);
		push_tick(levels_with(5, 1'b1));
		// restart while busy, then time out
		push_start(3, 1'b1, 50);
		push_tick(levels_with(3, 1'b0));
		push_start(4, 1'b0, 2);
		push_tick(levels_with(4, 1'b0));
		push_tick(levels_with(4, 1'b0));
		// pulse ends on the tick that would also time out
		push_start(2, 1'b1, 3);
		push_tick(levels_with(2, 1'b0));
		push_tick(levels_with(2, 1'b1));
		push_tick(levels_with(2, 1'b0));

		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		for (int p = 0; p < 4; p++) begin
			@(negedge clk);
			send_idle_pct  = send_pcts[p];
			recv_stall_pct = recv_pcts[p];
			while (pending.size() < PHASE_ITEMS)
				add_pulse_run();
			if (p == 0)
				hold_asks++;
			while (pending.size() != 0 || in_valid)
				@(negedge clk);
		end

		while (captures_due.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
		if (mismatches == 0)
			$display("pulse_width_capture_top_test: clean");
		else
			$display("pulse_width_capture_top_test: errors");
		$finish;
	end

endmodule
